// ===== rtl/resd_pkg.sv =====
// Shared types and constants of the readout event stream decoder.
package resd_pkg;

   localparam int CHANNEL_COUNT = 48;
   localparam int WINDOW_CLOCKS = 32;

   localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int POS_W = $clog2(2 * CHANNEL_COUNT);
   localparam int CLK_W = $clog2(WINDOW_CLOCKS + 1);

   localparam int CMDQ_DEPTH = 4;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   localparam logic [6:0]  HIT_COUNT_MAX = 7'h7f;
   localparam logic [20:0] CHARGE_MAX    = 21'h1fffff;

   typedef enum logic [0:0] {
      CSR_RAW_MODE_ID      = 1'b0,
      CSR_SUPPRESS_MODE_ID = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_RAW_HDR   = 3'd0,
      KIND_SUP_HDR   = 3'd1,
      KIND_EMPTY     = 3'd2,
      KIND_HIT       = 3'd3,
      KIND_SUMMARY   = 3'd4,
      KIND_EVENT_END = 3'd5,
      KIND_BAD_ID    = 3'd6,
      KIND_BAD_CHAN  = 3'd7
   } kind_type;

   // Work items passed from the byte parser to the channel store.
   typedef enum logic [2:0] {
      OP_NOP  = 3'd0,  // nothing but possibly the end of the event
      OP_HDR  = 3'd1,  // new header: latch it, clear stores, emit record
      OP_ADC  = 3'd2,  // add an ADC word to a channel charge
      OP_RHIT = 3'd3,  // raw hit: emit with the channel hit count, bump it
      OP_SCNT = 3'd4,  // store a suppress hit count
      OP_SCOT = 3'd5,  // store a count over threshold
      OP_SQ   = 3'd6,  // store a suppress charge
      OP_EMIT = 3'd7   // emit the record as built by the parser
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        fin;
      logic        fin_raw;
      logic        last;
      kind_type    kind;
      logic [47:0] wide;
      logic [7:0]  chan;
      logic [6:0]  count;
      logic [16:0] drift;
      logic [6:0]  slot;
      logic [15:0] word;
      logic [7:0]  board;
      logic [15:0] send;
      logic [14:0] tt;
      logic [15:0] len;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  board;
      logic [15:0] send;
      logic [14:0] tt;
      logic [15:0] len;
      logic [47:0] wide;
      logic [7:0]  chan;
      logic [6:0]  count;
      logic [16:0] drift;
      logic [6:0]  slot;
      logic [20:0] charge;
      logic        last;
   } rec_type;

endpackage

// ===== rtl/resd_front.sv =====
// Byte parser: walks the header and payload layout and issues store commands.
module resd_front import resd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] raw_id,
   input  logic [7:0] sup_id,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   output logic       cmd_push,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      PH_HEADER = 8'b00000001,
      PH_RAW    = 8'b00000010,
      PH_SKIP   = 8'b00000100,
      PH_SCHAN  = 8'b00001000,
      PH_SCOUNT = 8'b00010000,
      PH_SCOT   = 8'b00100000,
      PH_SQ     = 8'b01000000,
      PH_STDC   = 8'b10000000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [15:0]        offset_ff, offset_in;
   logic [63:0]        hdr0_ff, hdr0_in;
   logic [31:0]        hdr1_ff, hdr1_in;
   logic [7:0]         hold_ff, hold_in;
   logic [7:0]         rchan_ff, rchan_in;
   logic [6:0]         left_ff, left_in;
   logic [6:0]         total_ff, total_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CLK_W-1:0]   rclk_ff, rclk_in;

   logic [15:0] word;
   logic [15:0] len;
   logic        odd;
   logic        good;
   logic [6:0]  n;
   logic [16:0] d;
   logic [31:0] tc;
   cmd_type     c;

   assign word = {hold_ff, data_byte};
   assign len  = hdr0_ff[15:0];
   assign odd  = offset_ff[0];
   assign good = (rchan_ff < 8'(CHANNEL_COUNT));
   assign n    = (data_byte[7:1] > 7'd3) ? (data_byte[7:1] - 7'd3) : 7'd0;
   assign tc   = {hdr1_ff[23:0], data_byte};

   always_comb begin
      phase_in  = phase_ff;
      offset_in = offset_ff;
      hdr0_in   = hdr0_ff;
      hdr1_in   = hdr1_ff;
      hold_in   = hold_ff;
      rchan_in  = rchan_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      pos_in    = pos_ff;
      rclk_in   = rclk_ff;
      d         = 17'd0;
      c         = '0;
      c.op      = OP_NOP;
      c.kind    = KIND_RAW_HDR;
      c.board   = hdr0_ff[55:48];
      c.send    = hdr0_ff[47:32];
      c.tt      = hdr0_ff[30:16];
      c.len     = hdr0_ff[15:0];

      if (phase_ff == PH_HEADER) begin
         if (offset_ff < 16'd8) begin
            hdr0_in = {hdr0_ff[55:0], data_byte};
         end else begin
            hdr1_in = {hdr1_ff[23:0], data_byte};
         end
         if (offset_ff < 16'd11) begin
            offset_in = offset_ff + 16'd1;
         end else begin
            offset_in = 16'd0;
            pos_in    = '0;
            rclk_in   = '0;
            c.op      = OP_HDR;
            c.last    = 1'b1;
            c.wide    = 48'(tc);
            priority if (len == 16'd0) begin
               c.kind = KIND_EMPTY;
            end else if (hdr0_ff[63:56] == raw_id) begin
               c.kind   = KIND_RAW_HDR;
               phase_in = PH_RAW;
            end else if (hdr0_ff[63:56] == sup_id) begin
               c.kind   = KIND_SUP_HDR;
               phase_in = PH_SCHAN;
            end else begin
               c.kind   = KIND_BAD_ID;
               c.wide   = 48'(hdr0_ff[63:56]);
               phase_in = PH_SKIP;
            end
         end
      end else begin
         unique case (phase_ff)
            PH_RAW: begin
               if (!odd) begin
                  hold_in = data_byte;
               end else if (rclk_ff < CLK_W'(WINDOW_CLOCKS)) begin
                  if (pos_ff == POS_W'(2 * CHANNEL_COUNT - 1)) begin
                     pos_in  = '0;
                     rclk_in = rclk_ff + 1'b1;
                  end else begin
                     pos_in = pos_ff + 1'b1;
                  end
                  if (pos_ff < POS_W'(CHANNEL_COUNT)) begin
                     c.op   = OP_ADC;
                     c.chan = 8'(pos_ff);
                     c.word = word;
                  end else if (word[15]) begin
                     d = {2'b00, word[14:0]} - {2'b00, hdr0_ff[30:16]};
                     if ($signed(d) > 17'sd0) begin
                        d = d - 17'd32768;
                     end
                     c.op    = OP_RHIT;
                     c.kind  = KIND_HIT;
                     c.chan  = 8'(pos_ff - POS_W'(CHANNEL_COUNT));
                     c.drift = d;
                     c.slot  = 7'(rclk_ff);
                  end
               end
            end
            PH_SCHAN: begin
               if (({1'b0, offset_ff} + 17'd2) < {1'b0, len}) begin
                  rchan_in = data_byte;
                  phase_in = PH_SCOUNT;
                  if (data_byte >= 8'(CHANNEL_COUNT)) begin
                     c.op   = OP_EMIT;
                     c.kind = KIND_BAD_CHAN;
                     c.chan = data_byte;
                  end
               end
            end
            PH_SCOUNT: begin
               left_in  = n;
               total_in = n;
               phase_in = PH_SCOT;
               if (good) begin
                  c.op    = OP_SCNT;
                  c.chan  = rchan_ff;
                  c.count = n;
               end
            end
            PH_SCOT: begin
               if (!odd) begin
                  hold_in = data_byte;
               end else begin
                  phase_in = PH_SQ;
                  if (good) begin
                     c.op   = OP_SCOT;
                     c.chan = rchan_ff;
                     c.word = word;
                  end
               end
            end
            PH_SQ: begin
               if (!odd) begin
                  hold_in = data_byte;
               end else begin
                  phase_in = (left_ff != 7'd0) ? PH_STDC : PH_SCHAN;
                  if (good) begin
                     c.op   = OP_SQ;
                     c.chan = rchan_ff;
                     c.word = word;
                  end
               end
            end
            PH_STDC: begin
               if (!odd) begin
                  hold_in = data_byte;
               end else begin
                  left_in = left_ff - 7'd1;
                  if (left_ff == 7'd1) begin
                     phase_in = PH_SCHAN;
                  end
                  if (good) begin
                     c.op    = OP_EMIT;
                     c.kind  = KIND_HIT;
                     c.chan  = rchan_ff;
                     c.count = total_ff - left_ff;
                     c.slot  = total_ff - left_ff;
                     c.drift = 17'd0 - {1'b0, word};
                  end
               end
            end
            default: begin
               // Payload of a packet with an unknown id is dropped.
            end
         endcase

         if (({1'b0, offset_ff} + 17'd1) >= {1'b0, len}) begin
            c.fin     = (phase_in != PH_SKIP);
            c.fin_raw = (phase_in == PH_RAW);
            phase_in  = PH_HEADER;
            offset_in = 16'd0;
         end else begin
            offset_in = offset_ff + 16'd1;
         end
         c.last = !c.fin;
      end
   end

   assign cmd      = c;
   assign cmd_push = byte_valid && ((c.op != OP_NOP) || c.fin);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= 16'd0;
         hdr0_ff   <= 64'd0;
         hdr1_ff   <= 32'd0;
         hold_ff   <= 8'd0;
         rchan_ff  <= 8'd0;
         left_ff   <= 7'd0;
         total_ff  <= 7'd0;
         pos_ff    <= '0;
         rclk_ff   <= '0;
      end else if (byte_valid) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         hdr0_ff   <= hdr0_in;
         hdr1_ff   <= hdr1_in;
         hold_ff   <= hold_in;
         rchan_ff  <= rchan_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
         pos_ff    <= pos_in;
         rclk_ff   <= rclk_in;
      end
   end

endmodule

// ===== rtl/resd_cmd_fifo.sv =====
// Short command queue between the byte parser and the channel store.
module resd_cmd_fifo import resd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type             mem [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]  wr_ff, rd_ff;
   logic [CMDQ_AW:0]    cnt_ff, cnt_in;

   assign full  = (cnt_ff == (CMDQ_AW + 1)'(CMDQ_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/resd_back.sv =====
// Channel store: executes commands against per-channel memory, sweeps summaries, queues records.
module resd_back import resd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cq_head,
   input  logic    cq_empty,
   output logic    cq_pop,
   output rec_type rsp_head,
   output logic    rsp_empty,
   input  logic    rsp_pop
);

   typedef enum logic [4:0] {
      B_IDLE   = 5'b00001,
      B_EXEC   = 5'b00010,
      B_SW_RD  = 5'b00100,
      B_SW_USE = 5'b01000,
      B_END    = 5'b10000
   } bstate_type;

   typedef struct packed {
      logic [20:0] charge;
      logic [6:0]  hits;
      logic [15:0] cot;
   } ent_type;

   bstate_type              st_ff, st_in;
   cmd_type                 cmd_ff;
   logic [7:0]              board_ff;
   logic [15:0]             send_ff;
   logic [14:0]             tt_ff;
   logic [15:0]             len_ff;
   logic [CHANNEL_COUNT-1:0] vld_ff;
   logic [CHANNEL_COUNT-1:0] map_ff;
   logic [6:0]              nch_ff;
   logic [CH_W-1:0]         sw_ff;

   ent_type                 mem [CHANNEL_COUNT];
   ent_type                 rd_data_ff;
   logic                    rd_vld_ff;
   logic                    rd_en;
   logic [CH_W-1:0]         rd_addr;
   ent_type                 ent;
   ent_type                 wr_ent;
   logic                    wr_en;
   logic [21:0]             adc_sum;

   logic                    emit_need;
   logic                    emit;
   logic                    advance;
   rec_type                 rec;

   rec_type                 oq [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0]      oq_wr_ff, oq_rd_ff;
   logic [RSPQ_AW:0]        oq_cnt_ff;
   logic                    oq_full;

   assign oq_full   = (oq_cnt_ff == (RSPQ_AW + 1)'(RSPQ_DEPTH));
   assign rsp_empty = (oq_cnt_ff == '0);
   assign rsp_head  = oq[oq_rd_ff];

   assign cq_pop  = (st_ff == B_IDLE) && !cq_empty;
   assign rd_en   = cq_pop || (st_ff == B_SW_RD);
   assign rd_addr = (st_ff == B_SW_RD) ? sw_ff : cq_head.chan[CH_W-1:0];
   assign ent     = rd_vld_ff ? rd_data_ff : '0;
   assign adc_sum = {1'b0, ent.charge} + {6'd0, cmd_ff.word};

   always_comb begin
      emit_need = 1'b0;
      unique case (st_ff)
         B_EXEC:   emit_need = (cmd_ff.op == OP_HDR) || (cmd_ff.op == OP_RHIT) ||
                               (cmd_ff.op == OP_EMIT);
         B_SW_USE: emit_need = cmd_ff.fin_raw || (ent.hits != 7'd0);
         B_END:    emit_need = 1'b1;
         default:  emit_need = 1'b0;
      endcase
   end

   assign advance = !emit_need || !oq_full;
   assign emit    = emit_need && !oq_full;

   // Record assembly.
   always_comb begin
      rec        = '0;
      rec.board  = board_ff;
      rec.send   = send_ff;
      rec.tt     = tt_ff;
      rec.len    = len_ff;
      rec.kind   = cmd_ff.kind;
      unique case (st_ff)
         B_EXEC: begin
            rec.last  = cmd_ff.last;
            rec.chan  = cmd_ff.chan;
            rec.count = cmd_ff.count;
            rec.drift = cmd_ff.drift;
            rec.slot  = cmd_ff.slot;
            if (cmd_ff.op == OP_HDR) begin
               rec.board = cmd_ff.board;
               rec.send  = cmd_ff.send;
               rec.tt    = cmd_ff.tt;
               rec.len   = cmd_ff.len;
               rec.wide  = cmd_ff.wide;
            end
            if (cmd_ff.op == OP_RHIT) begin
               rec.count = ent.hits;
            end
         end
         B_SW_USE: begin
            rec.kind   = KIND_SUMMARY;
            rec.wide   = 48'(ent.cot);
            rec.chan   = 8'(sw_ff);
            rec.count  = ent.hits;
            rec.charge = ent.charge;
         end
         B_END: begin
            rec.kind  = KIND_EVENT_END;
            rec.wide  = 48'(map_ff);
            rec.count = nch_ff;
            rec.last  = 1'b1;
         end
         default: begin
            rec.last = 1'b0;
         end
      endcase
   end

   // Channel store update.
   always_comb begin
      wr_ent = ent;
      wr_en  = 1'b0;
      if ((st_ff == B_EXEC) && advance) begin
         unique case (cmd_ff.op)
            OP_ADC: begin
               wr_en         = 1'b1;
               wr_ent.charge = adc_sum[21] ? CHARGE_MAX : adc_sum[20:0];
            end
            OP_RHIT: begin
               wr_en = 1'b1;
               if (ent.hits != HIT_COUNT_MAX) begin
                  wr_ent.hits = ent.hits + 7'd1;
               end
            end
            OP_SCNT: begin
               wr_en       = 1'b1;
               wr_ent.hits = cmd_ff.count;
            end
            OP_SCOT: begin
               wr_en      = 1'b1;
               wr_ent.cot = cmd_ff.word;
            end
            OP_SQ: begin
               wr_en         = 1'b1;
               wr_ent.charge = {5'd0, cmd_ff.word};
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         B_IDLE:   if (cq_pop) st_in = B_EXEC;
         B_EXEC:   if (advance) st_in = cmd_ff.fin ? B_SW_RD : B_IDLE;
         B_SW_RD:  st_in = B_SW_USE;
         B_SW_USE: begin
            if (advance) begin
               st_in = (sw_ff == CH_W'(CHANNEL_COUNT - 1)) ? B_END : B_SW_RD;
            end
         end
         B_END:    if (advance) st_in = B_IDLE;
         default:  st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[cmd_ff.chan[CH_W-1:0]] <= wr_ent;
      end
      if (cq_pop) begin
         cmd_ff <= cq_head;
      end
      if ((st_ff == B_EXEC) && advance && (cmd_ff.op == OP_HDR)) begin
         board_ff <= cmd_ff.board;
         send_ff  <= cmd_ff.send;
         tt_ff    <= cmd_ff.tt;
         len_ff   <= cmd_ff.len;
      end
      if (emit) begin
         oq[oq_wr_ff] <= rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= B_IDLE;
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         map_ff    <= '0;
         nch_ff    <= 7'd0;
         sw_ff     <= '0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
         if ((st_ff == B_EXEC) && advance && (cmd_ff.op == OP_HDR)) begin
            vld_ff <= '0;
         end else if (wr_en) begin
            vld_ff[cmd_ff.chan[CH_W-1:0]] <= 1'b1;
         end
         if ((st_ff == B_EXEC) && advance) begin
            sw_ff  <= '0;
            map_ff <= '0;
            nch_ff <= 7'd0;
         end
         if ((st_ff == B_SW_USE) && advance) begin
            sw_ff <= sw_ff + 1'b1;
            if (ent.hits != 7'd0) begin
               map_ff[sw_ff] <= 1'b1;
               nch_ff        <= nch_ff + 7'd1;
            end
         end
         if (emit) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
         if (emit && !(rsp_pop && !rsp_empty)) begin
            oq_cnt_ff <= oq_cnt_ff + 1'b1;
         end else if (!emit && rsp_pop && !rsp_empty) begin
            oq_cnt_ff <= oq_cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/readout_event_stream_decoder.sv =====
// Top level of the readout event stream decoder: configuration, parser, queue and channel store.
//
// The decoder takes one event stream byte per word on the req_ side and returns decoded
// records on the rsp_ side, oldest first; both sides behave as queues. A byte parser takes
// a byte in every cycle in which req_full is low: header bytes other than the last and the
// high byte of every payload word are absorbed by the parser alone. Bytes that touch a channel
// or make a record become commands and go through a four-entry command queue to the channel
// store, which reads the channel memory for each command and then updates it or makes a record,
// so a stream of data words can be taken at about one byte per cycle until the queue fills. At
// the end of each raw or suppressed event the store sweeps all channels, reading each one and
// making a summary record if it had hits or the event is raw, then makes an event end record
// before the next command is taken; the parser keeps filling the command queue meanwhile.
// Results leave through a four-entry record queue, so a stalled consumer holds the store and
// then the parser. The packet ids (reset to 34 and 32) that select raw and zero-suppressed
// layouts must be written through csr_ only while the block is idle; the block does not check it.
module readout_event_stream_decoder import resd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_record_kind,
   output logic [7:0]  rsp_board_number,
   output logic [15:0] rsp_send_count,
   output logic [14:0] rsp_trigger_stamp,
   output logic [15:0] rsp_payload_length,
   output logic [47:0] rsp_wide_value,
   output logic [7:0]  rsp_channel_number,
   output logic [6:0]  rsp_count_value,
   output logic signed [16:0] rsp_drift_value,
   output logic [6:0]  rsp_clock_slot,
   output logic [20:0] rsp_charge_sum,
   output logic        rsp_last_result
);

   logic [7:0] raw_id_ff;
   logic [7:0] sup_id_ff;
   logic       byte_valid;
   logic       cmd_push;
   cmd_type    cmd;
   cmd_type    cq_head;
   logic       cq_empty;
   logic       cq_pop;
   rec_type    head;

   // Packet id registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_id_ff <= 8'd34;
         sup_id_ff <= 8'd32;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAW_MODE_ID:      raw_id_ff <= csr_wdata;
            CSR_SUPPRESS_MODE_ID: sup_id_ff <= csr_wdata;
            default:              raw_id_ff <= raw_id_ff;
         endcase
      end
   end

   // A byte is taken whenever the command queue has room for what it may cause.
   assign byte_valid = req_push && !req_full;

   resd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .raw_id     (raw_id_ff),
      .sup_id     (sup_id_ff),
      .byte_valid (byte_valid),
      .data_byte  (req_data_byte),
      .cmd_push   (cmd_push),
      .cmd        (cmd)
   );

   resd_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (req_full),
      .pop      (cq_pop),
      .head     (cq_head),
      .empty    (cq_empty)
   );

   resd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_head   (cq_head),
      .cq_empty  (cq_empty),
      .cq_pop    (cq_pop),
      .rsp_head  (head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_record_kind    = head.kind;
   assign rsp_board_number   = head.board;
   assign rsp_send_count     = head.send;
   assign rsp_trigger_stamp  = head.tt;
   assign rsp_payload_length = head.len;
   assign rsp_wide_value     = head.wide;
   assign rsp_channel_number = head.chan;
   assign rsp_count_value    = head.count;
   assign rsp_drift_value    = $signed(head.drift);
   assign rsp_clock_slot     = head.slot;
   assign rsp_charge_sum     = head.charge;
   assign rsp_last_result    = head.last;

`ifndef SYNTHESIS
   // An event end record always closes the results of its byte.
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_record_kind == KIND_EVENT_END)) |-> rsp_last_result)
      else $error("event end record without last flag");

   // Header records are the only result of the last header byte.
   a_hdr_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && ((rsp_record_kind == KIND_RAW_HDR) ||
                      (rsp_record_kind == KIND_SUP_HDR) ||
                      (rsp_record_kind == KIND_EMPTY) ||
                      (rsp_record_kind == KIND_BAD_ID))) |-> rsp_last_result)
      else $error("header record without last flag");

   // Only a hit record carries a drift time.
   a_drift_only_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_record_kind != KIND_HIT)) |-> (rsp_drift_value == 17'sd0))
      else $error("drift time on a non-hit record");
`endif

endmodule
